FILE: design/rlp_pkg.sv
// Shared types and register codes for the resonant lowpass unit.
package rlp_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESONANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CUTOFF,
        ST_ADD_VEL,
        ST_ADD_POS,
        ST_SCALE_VEL
    } ctrl_state_t;

    typedef struct packed {
        logic load_diff;     // capture sample - position
        logic mul_cutoff;    // product <= diff * c
        logic add_vel;       // velocity <= sat(velocity + accel)
        logic add_pos;       // position update, product <= velocity * r
        logic scale_vel;     // velocity <= rounded product, result to output
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;      // output register holds a result not yet taken
    } dp_status_t;

endpackage

FILE: design/rlp_ctrl.sv
// Sequencer for one filter step over the shared multiplier.
module rlp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rlp_pkg::dp_status_t status,
    output rlp_pkg::dp_cmd_t    cmd
);

    rlp_pkg::ctrl_state_t state_reg;
    rlp_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rlp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_diff = 1'b1;
                    state_next    = rlp_pkg::ST_MUL_CUTOFF;
                end
            end
            rlp_pkg::ST_MUL_CUTOFF: begin
                cmd.mul_cutoff = 1'b1;
                state_next     = rlp_pkg::ST_ADD_VEL;
            end
            rlp_pkg::ST_ADD_VEL: begin
                cmd.add_vel = 1'b1;
                state_next  = rlp_pkg::ST_ADD_POS;
            end
            rlp_pkg::ST_ADD_POS: begin
                cmd.add_pos = 1'b1;
                state_next  = rlp_pkg::ST_SCALE_VEL;
            end
            rlp_pkg::ST_SCALE_VEL: begin
                // position is final here, so the next request may load now
                if (!status.out_busy) begin
                    cmd.scale_vel = 1'b1;
                    s_ready       = 1'b1;
                    if (s_valid) begin
                        cmd.load_diff = 1'b1;
                        state_next    = rlp_pkg::ST_MUL_CUTOFF;
                    end else begin
                        state_next    = rlp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rlp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/rlp_datapath.sv
// State registers, coefficient registers, shared multiplier and saturation logic.
module rlp_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int STATE_BITS     = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rlp_pkg::dp_cmd_t                      cmd,
    output rlp_pkg::dp_status_t                   status,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    input  logic                                  cfg_valid,
    input  logic [rlp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]             cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out
);

    localparam int SW = SAMPLE_BITS;
    localparam int TW = STATE_BITS;
    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int RW = COEF_FRAC_BITS;
    localparam int DW = ((SW > TW) ? SW : TW) + 1;   // exact difference
    localparam int PW = TW + CW + 1;                 // product
    localparam int AW = PW - F;                      // rounded product
    localparam int VW = AW + 1;                      // velocity sum

    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

    // configuration
    logic [CW-1:0] cutoff_reg;
    logic [RW-1:0] resonance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg    <= '0;
            resonance_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rlp_pkg::REG_CUTOFF:    cutoff_reg    <= cfg_data;
                rlp_pkg::REG_RESONANCE: resonance_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // filter state
    logic signed [TW-1:0] pos_reg, pos_next;
    logic signed [TW-1:0] vel_reg, vel_next;
    logic signed [TW-1:0] diff_reg, diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_reg, out_next;

    // sample - position, exact then saturated
    logic signed [DW-1:0] diff_full;
    assign diff_full = $signed({{(DW-SW){sample_in[SW-1]}}, sample_in})
                     - $signed({{(DW-TW){pos_reg[TW-1]}}, pos_reg});

    always_comb begin
        if (diff_full[DW-1] == 1'b0 && diff_full[DW-2:TW-1] != '0) begin
            diff_next = {1'b0, {(TW-1){1'b1}}};
        end else if (diff_full[DW-1] == 1'b1 && diff_full[DW-2:TW-1] != '1) begin
            diff_next = {1'b1, {(TW-1){1'b0}}};
        end else begin
            diff_next = diff_full[TW-1:0];
        end
    end

    // shared multiplier: diff * c, then velocity * r
    logic signed [TW-1:0] mul_a;
    logic signed [CW:0]   mul_b;

    always_comb begin
        if (cmd.add_pos) begin
            mul_a = vel_reg;
            mul_b = $signed({{(CW+1-RW){1'b0}}, resonance_reg});
        end else begin
            mul_a = diff_reg;
            mul_b = $signed({1'b0, cutoff_reg});
        end
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // round half up, floor shift
    logic signed [PW-1:0] prod_rnd;
    logic signed [AW-1:0] scaled;
    assign prod_rnd = prod_reg + HALF;
    assign scaled   = AW'(prod_rnd >>> F);

    // velocity + accel
    logic signed [VW-1:0] vsum;
    logic signed [TW-1:0] v1_sat;
    assign vsum = VW'(vel_reg) + VW'(scaled);

    always_comb begin
        if (vsum[VW-1] == 1'b0 && vsum[VW-2:TW-1] != '0) begin
            v1_sat = {1'b0, {(TW-1){1'b1}}};
        end else if (vsum[VW-1] == 1'b1 && vsum[VW-2:TW-1] != '1) begin
            v1_sat = {1'b1, {(TW-1){1'b0}}};
        end else begin
            v1_sat = vsum[TW-1:0];
        end
    end

    // scaled velocity
    logic signed [TW-1:0] v2_sat;
    always_comb begin
        if (scaled[AW-1] == 1'b0 && scaled[AW-2:TW-1] != '0) begin
            v2_sat = {1'b0, {(TW-1){1'b1}}};
        end else if (scaled[AW-1] == 1'b1 && scaled[AW-2:TW-1] != '1) begin
            v2_sat = {1'b1, {(TW-1){1'b0}}};
        end else begin
            v2_sat = scaled[TW-1:0];
        end
    end

    // position + velocity
    logic signed [TW:0]   psum;
    logic signed [TW-1:0] p1_sat;
    assign psum = (TW+1)'(pos_reg) + (TW+1)'(vel_reg);

    always_comb begin
        if (psum[TW] != psum[TW-1]) begin
            p1_sat = psum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
            p1_sat = psum[TW-1:0];
        end
    end

    // result: position to sample range
    generate
        if (SW >= TW) begin : g_out_wide
            assign out_next = SW'(pos_reg);
        end else begin : g_out_sat
            always_comb begin
                if (pos_reg[TW-1] == 1'b0 && pos_reg[TW-2:SW-1] != '0) begin
                    out_next = {1'b0, {(SW-1){1'b1}}};
                end else if (pos_reg[TW-1] == 1'b1 && pos_reg[TW-2:SW-1] != '1) begin
                    out_next = {1'b1, {(SW-1){1'b0}}};
                end else begin
                    out_next = pos_reg[SW-1:0];
                end
            end
        end
    endgenerate

    always_comb begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        if (cmd.add_vel) begin
            vel_next = v1_sat;
        end
        if (cmd.scale_vel) begin
            vel_next = v2_sat;
        end
        if (cmd.add_pos) begin
            pos_next = p1_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            vel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            if (cmd.scale_vel) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.mul_cutoff || cmd.add_pos) begin
            prod_reg <= prod_next;
        end
        if (cmd.scale_vel) begin
            out_reg <= out_next;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_reg;

endmodule

FILE: design/resonant_lowpass_12db_unit.sv
// Two-pole resonant lowpass (12 dB/octave), mass-spring form; top level.
//
// Each request carries one signed sample and returns one filtered sample.
// A step runs velocity += (sample - position) * cutoff_coef, position +=
// velocity, velocity *= resonance_coef, with round-half-up products and
// saturating state; the result is the new position saturated to the sample
// width. Both products go through one shared multiplier: a step runs the
// multiply, velocity-add, position-add and velocity-scale states before the
// result register loads; a back-to-back request is taken in the last state,
// as scaling finishes. A result waiting in the output register holds
// off the end of the following step until it is taken. Coefficients are
// written through the cfg port: index 0 is cutoff_coef (COEF_FRAC_BITS+2
// bits), index 1 is resonance_coef (low COEF_FRAC_BITS bits of cfg_data);
// write them only while no request is in flight.
module resonant_lowpass_12db_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int STATE_BITS     = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]          cfg_data
);

    rlp_pkg::dp_cmd_t    cmd;
    rlp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rlp_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (s_sample_in),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .sample_out (m_sample_out)
    );

endmodule
